// File: sv/tdcrw_pkg.sv
// ----------------------------------------------------------------------------
// tdcrw_pkg
// shared types, word type codes and field positions of the tdc readout decoder
// ----------------------------------------------------------------------------
`default_nettype none

package tdcrw_pkg;

   // default configuration
   localparam int unsigned CHANNELS_DEF = 128;
   localparam int unsigned MAX_HITS_DEF = 255;

   // counter width of one hit counter entry
   localparam int unsigned HIT_W = 8;

   // number of flag bits in an error word
   localparam int unsigned ERR_BITS = 14;

   // type codes found in bits 31..27 of a readout word
   localparam logic [4:0] TC_MEAS     = 5'd0;
   localparam logic [4:0] TC_TDC_HDR  = 5'd1;
   localparam logic [4:0] TC_TDC_TRL  = 5'd3;
   localparam logic [4:0] TC_TDC_ERR  = 5'd4;
   localparam logic [4:0] TC_GLB_HDR  = 5'd8;
   localparam logic [4:0] TC_GLB_TRL  = 5'd16;
   localparam logic [4:0] TC_EXT_TRIG = 5'd17;

   // error code reported when no flag bit is set, or for non-error words
   localparam logic [3:0] ERR_NONE = 4'd14;

   typedef enum logic [3:0] {
      KIND_MEAS,
      KIND_TDC_HDR,
      KIND_TDC_TRL,
      KIND_ERROR,
      KIND_GLB_HDR,
      KIND_GLB_TRL,
      KIND_EXT_TRIG,
      KIND_UNKNOWN,
      KIND_CLEARED
   } word_kind_type;

   // decoded word plus the side effects it asks for
   typedef struct packed {
      logic          ok;
      word_kind_type word_kind;
      logic          edge_res;
      logic [6:0]    channel;
      logic [18:0]   measurement;
      logic [3:0]    error_code;
      logic [26:0]   value_main;
      logic [11:0]   value_aux;
      logic          hit_wr;
      logic          hdr_wr;
      logic          trl_chk;
      logic          clear;
   } dec_type;

   // commands to the hit counter memory for the item in the decode stage
   typedef struct packed {
      logic upd;
      logic clear;
   } hit_cmd_type;

endpackage

`default_nettype wire

// File: sv/tdcrw_channels.sv
// ----------------------------------------------------------------------------
// tdcrw channels
// valid/ready channel interfaces for readout word transactions and results
// ----------------------------------------------------------------------------
`default_nettype none

interface tdcrw_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] data_word;

   modport source (output valid, req_type, data_word, input ready);
   modport sink (input valid, req_type, data_word, output ready);
endinterface

interface tdcrw_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [3:0]  word_kind;
   logic        edge_res;
   logic [6:0]  channel;
   logic [18:0] measurement;
   logic [7:0]  hit_number;
   logic [3:0]  error_code;
   logic        id_mismatch;
   logic [26:0] value_main;
   logic [11:0] value_aux;

   modport source (
      output valid, ok, word_kind, edge_res, channel, measurement, hit_number,
             error_code, id_mismatch, value_main, value_aux,
      input  ready
   );
   modport sink (
      input  valid, ok, word_kind, edge_res, channel, measurement, hit_number,
             error_code, id_mismatch, value_main, value_aux,
      output ready
   );
endinterface

`default_nettype wire

// File: sv/tdcrw_word_dec.sv
// ----------------------------------------------------------------------------
// tdcrw_word_dec
// field extraction and classification of one readout word or clear request
// ----------------------------------------------------------------------------
`default_nettype none

module tdcrw_word_dec
   import tdcrw_pkg::*;
#(
   parameter int unsigned CHANNELS = CHANNELS_DEF
) (
   input  logic        req_type,
   input  logic [31:0] data_word,
   output dec_type     dec
);

   localparam logic [7:0] CH_LIMIT = 8'(CHANNELS);

   logic ch_ok;

   assign ch_ok = ({1'b0, data_word[25:19]} < CH_LIMIT);

   always_comb begin
      dec            = '0;
      dec.word_kind  = KIND_UNKNOWN;
      dec.error_code = ERR_NONE;
      if (req_type) begin
         dec.ok        = 1'b1;
         dec.word_kind = KIND_CLEARED;
         dec.clear     = 1'b1;
      end else begin
         case (data_word[31:27])
            TC_MEAS: begin
               dec.word_kind   = KIND_MEAS;
               dec.edge_res    = data_word[26];
               dec.channel     = data_word[25:19];
               dec.measurement = data_word[18:0];
               dec.ok          = ch_ok;
               dec.hit_wr      = ch_ok;
            end
            TC_TDC_HDR: begin
               dec.ok         = 1'b1;
               dec.word_kind  = KIND_TDC_HDR;
               dec.value_main = 27'(data_word[11:0]);
               dec.value_aux  = data_word[23:12];
               dec.hdr_wr     = 1'b1;
            end
            TC_TDC_TRL: begin
               dec.ok         = 1'b1;
               dec.word_kind  = KIND_TDC_TRL;
               dec.value_main = 27'(data_word[11:0]);
               dec.value_aux  = data_word[23:12];
               dec.trl_chk    = 1'b1;
            end
            TC_TDC_ERR: begin
               dec.word_kind = KIND_ERROR;
               // highest flagged bit wins
               for (int i = 0; i < ERR_BITS; i++) begin
                  if (data_word[i]) begin
                     dec.error_code = 4'(i);
                  end
               end
            end
            TC_GLB_HDR: begin
               dec.ok         = 1'b1;
               dec.word_kind  = KIND_GLB_HDR;
               dec.value_main = 27'(data_word[26:5]);
            end
            TC_GLB_TRL: begin
               dec.ok         = 1'b1;
               dec.word_kind  = KIND_GLB_TRL;
               dec.value_main = 27'(data_word[20:5]);
               dec.value_aux  = 12'(data_word[26:24]);
            end
            TC_EXT_TRIG: begin
               dec.ok         = 1'b1;
               dec.word_kind  = KIND_EXT_TRIG;
               dec.value_main = data_word[26:0];
            end
            default: begin
               dec.word_kind = KIND_UNKNOWN;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: sv/tdcrw_hit_ram.sv
// ----------------------------------------------------------------------------
// tdcrw_hit_ram
// per-channel, per-edge hit counters in a synchronous memory with
// read-modify-write, write forwarding and per-entry valid bits for clear
// ----------------------------------------------------------------------------
`default_nettype none

module tdcrw_hit_ram
   import tdcrw_pkg::*;
#(
   parameter int unsigned CHANNELS = CHANNELS_DEF,
   parameter int unsigned MAX_HITS = MAX_HITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic             rd_edge,
   input  logic [6:0]       rd_channel,
   input  hit_cmd_type      cmd,
   output logic [HIT_W-1:0] hit_count
);

   localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned AW    = CH_W + 1;
   localparam int unsigned DEPTH = 2 ** AW;
   localparam logic [HIT_W-1:0] HIT_CAP =
      (MAX_HITS < 255) ? HIT_W'(MAX_HITS) : {HIT_W{1'b1}};

   logic [HIT_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [HIT_W-1:0] rd_data_ff;
   logic [AW-1:0]    addr_ff;
   logic             fwd_ff;
   logic [HIT_W-1:0] fwd_data_ff;
   logic [AW-1:0]    rd_addr;
   logic [HIT_W-1:0] cur;

   assign rd_addr = {rd_edge, rd_channel[CH_W-1:0]};

   // write in the same cycle as the read returns the just-written value
   always_comb begin
      if (fwd_ff) begin
         cur = fwd_data_ff;
      end else if (vld_ff[addr_ff]) begin
         cur = rd_data_ff;
      end else begin
         cur = '0;
      end
      hit_count = (cur < HIT_CAP) ? cur + HIT_W'(1) : cur;
   end

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         mem[addr_ff] <= hit_count;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         addr_ff     <= rd_addr;
         fwd_data_ff <= hit_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         fwd_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            vld_ff <= '0;
         end else if (cmd.upd) begin
            vld_ff[addr_ff] <= 1'b1;
         end
         if (rd_en) begin
            fwd_ff <= cmd.upd && (addr_ff == rd_addr);
         end
      end
   end

endmodule

`default_nettype wire

// File: sv/tdc_readout_word_decoder.sv
// ----------------------------------------------------------------------------
// tdc_readout_word_decoder
// decodes multi-hit tdc readout words, numbers hits per channel and edge
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          payload
//   req_ch   in   valid / ready      req_type, data_word
//   rsp_ch   out  valid / ready      ok, word_kind, edge_res, channel,
//                                    measurement, hit_number, error_code,
//                                    id_mismatch, value_main, value_aux
//
// one transaction per cycle sustained while rsp_ch does not stall; a taken
// request passes the counter memory read and word register, then decode into
// the output register, before its result is offered
// the hit counters sit in one memory of 2 x channels entries, with channels
// rounded up to a power of two, read when a word is taken and written back when it leaves the decode stage
// reset is synchronous; counters read as zero right after reset or a clear,
// through per-entry valid bits, so there is no clearing sweep
// a stalled result holds the decode stage; req_ch stays ready while the
// output register drains or is empty
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_readout_word_decoder
   import tdcrw_pkg::*;
#(
   parameter int unsigned CHANNELS = CHANNELS_DEF,
   parameter int unsigned MAX_HITS = MAX_HITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tdcrw_req_if.sink  req_ch,
   tdcrw_rsp_if.source rsp_ch
);

   // decode stage
   logic        s1_valid_ff;
   logic        s1_type_ff;
   logic [31:0] s1_word_ff;

   // output register
   logic        rsp_valid_ff;
   logic        ok_ff;
   logic [3:0]  word_kind_ff;
   logic        edge_res_ff;
   logic [6:0]  channel_ff;
   logic [18:0] measurement_ff;
   logic [7:0]  hit_number_ff;
   logic [3:0]  error_code_ff;
   logic        id_mismatch_ff;
   logic [26:0] value_main_ff;
   logic [11:0] value_aux_ff;

   // event id of the last tdc header
   logic [11:0] header_id_ff;

   logic             accept;
   logic             advance;
   dec_type          dec;
   hit_cmd_type      hit_cmd;
   logic [HIT_W-1:0] hit_count;

   // the decode stage moves whenever the output register is free or drains
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;

   assign hit_cmd.upd   = advance && dec.hit_wr;
   assign hit_cmd.clear = advance && dec.clear;

   tdcrw_word_dec #(
      .CHANNELS (CHANNELS)
   ) u_dec (
      .req_type  (s1_type_ff),
      .data_word (s1_word_ff),
      .dec       (dec)
   );

   // counter address comes straight from the incoming word
   tdcrw_hit_ram #(
      .CHANNELS (CHANNELS),
      .MAX_HITS (MAX_HITS)
   ) u_hit_ram (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_edge    (req_ch.data_word[26]),
      .rd_channel (req_ch.data_word[25:19]),
      .cmd        (hit_cmd),
      .hit_count  (hit_count)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         header_id_ff <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // header id updates in order with the result stream
         if (advance && dec.clear) begin
            header_id_ff <= '0;
         end else if (advance && dec.hdr_wr) begin
            header_id_ff <= dec.value_aux;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_type_ff <= req_ch.req_type;
         s1_word_ff <= req_ch.data_word;
      end
      if (advance) begin
         ok_ff          <= dec.ok;
         word_kind_ff   <= dec.word_kind;
         edge_res_ff    <= dec.edge_res;
         channel_ff     <= dec.channel;
         measurement_ff <= dec.measurement;
         hit_number_ff  <= dec.hit_wr ? hit_count : '0;
         error_code_ff  <= dec.error_code;
         id_mismatch_ff <= dec.trl_chk && (dec.value_aux != header_id_ff);
         value_main_ff  <= dec.value_main;
         value_aux_ff   <= dec.value_aux;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.ok          = ok_ff;
   assign rsp_ch.word_kind   = word_kind_ff;
   assign rsp_ch.edge_res    = edge_res_ff;
   assign rsp_ch.channel     = channel_ff;
   assign rsp_ch.measurement = measurement_ff;
   assign rsp_ch.hit_number  = hit_number_ff;
   assign rsp_ch.error_code  = error_code_ff;
   assign rsp_ch.id_mismatch = id_mismatch_ff;
   assign rsp_ch.value_main  = value_main_ff;
   assign rsp_ch.value_aux   = value_aux_ff;

endmodule

`default_nettype wire

// File: sv/tdcrw_checker.sv
// ----------------------------------------------------------------------------
// tdcrw_checker
// port-level checks of the tdc readout word decoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tdcrw_checker
   import tdcrw_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_ok,
   input logic [3:0] rsp_word_kind,
   input logic [7:0] rsp_hit_number
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // an empty output register never blocks the request side
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // a new result traces back to a request taken ahead of it through the decode stage
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without matching request");

   // hit numbers only come with good measurement words
   a_hit_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_hit_number != 8'd0) |->
         rsp_ok && (rsp_word_kind == KIND_MEAS))
      else $error("hit number on wrong word kind");

endmodule

bind tdc_readout_word_decoder tdcrw_checker u_tdcrw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_ok         (rsp_ch.ok),
   .rsp_word_kind  (rsp_ch.word_kind),
   .rsp_hit_number (rsp_ch.hit_number)
);

`default_nettype wire
